/* design/sebu_pkg.sv */
package sebu_pkg;

    localparam int ROSTER_DEPTH = 16;
    localparam int IDX_W        = $clog2(ROSTER_DEPTH);
    localparam int FILL_W       = $clog2(ROSTER_DEPTH + 1);
    // scan counter runs two past the fill to drain the score pipeline
    localparam int SCAN_W       = FILL_W + 1;
    localparam int MAX_RESULTS  = 32;
    localparam int NRES_W       = $clog2(MAX_RESULTS + 1);
    localparam int CQ_DEPTH     = 2;
    localparam int CQ_PTR_W     = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W     = $clog2(CQ_DEPTH + 1);
    localparam int RQ_DEPTH     = 4;
    localparam int RQ_PTR_W     = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W     = $clog2(RQ_DEPTH + 1);
    localparam int SCORE_W      = 48;

    localparam logic [31:0] FREEZE_DELAY_RST = 32'd300;
    localparam logic [4:0]  MAX_LIVE_RST     = 5'd16;
    localparam logic [4:0]  MAX_VISUAL_RST   = 5'd0;

    typedef enum logic [1:0] {
        CMD_SPAWN   = 2'd0,
        CMD_SETTLE  = 2'd1,
        CMD_ENFORCE = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_FALLING = 2'd0,
        PH_SETTLED = 2'd1,
        PH_FROZEN  = 2'd2,
        PH_RETIRED = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        K_SPAWNED  = 3'd0,
        K_REJECTED = 3'd1,
        K_FROZEN   = 3'd2,
        K_RETIRED  = 3'd3,
        K_DONE     = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        REG_FREEZE_DELAY = 2'd0,
        REG_MAX_LIVE     = 2'd1,
        REG_MAX_VISUAL   = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SETTLE,
        ST_FREEZE,
        ST_LIVE,
        ST_SCORE,
        ST_RETIRE_SETUP,
        ST_RETIRE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] freeze_delay;
        logic [4:0]  max_live;
        logic [4:0]  max_visual;
    } cfg_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [3:0]  entry_index;
        logic [15:0] entry_size;
        logic [31:0] now_tick;
    } item_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] slot;
        logic       last;
    } res_t;

endpackage

/* design/settled_entry_eviction_budget_unit.sv */
// channel   | handshake          | payload
// ----------+--------------------+----------------------------------------
// request   | push / full        | cmd, entry_index, entry_size, now_tick
// result    | empty / pop        | kind, slot, last
// config    | cfg_wr_en          | cfg_index, cfg_wdata
//
// once the back end takes a request, spawn runs decode and finish, settle runs
// decode, settle and finish; enforce walks the roster once for the age freeze
// and, unless max_visual is zero, once for the retire, one entry a cycle while
// no result stalls; a live-cap freeze adds a live check and a 16x32 score scan.
// reset clears the roster fill and all queues; entry contents need no clear.
// a two-deep request queue accepts while the back end works; a full result
// queue stalls the back end at its next result.
module settled_entry_eviction_budget_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  cmd,
    input  logic [3:0]  entry_index,
    input  logic [15:0] entry_size,
    input  logic [31:0] now_tick,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  kind,
    output logic [3:0]  slot,
    output logic        last,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    sebu_pkg::cfg_t   cfg_reg;
    sebu_pkg::item_t  cq_item;
    logic             cq_avail;
    logic             cq_take;
    sebu_pkg::res_t   rq_din;
    sebu_pkg::res_t   rq_dout;
    logic             rq_wr;
    logic             rq_full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.freeze_delay <= sebu_pkg::FREEZE_DELAY_RST;
            cfg_reg.max_live     <= sebu_pkg::MAX_LIVE_RST;
            cfg_reg.max_visual   <= sebu_pkg::MAX_VISUAL_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (sebu_pkg::reg_idx_t'(cfg_index))
                sebu_pkg::REG_FREEZE_DELAY: cfg_reg.freeze_delay <= cfg_wdata;
                sebu_pkg::REG_MAX_LIVE:     cfg_reg.max_live     <= cfg_wdata[4:0];
                sebu_pkg::REG_MAX_VISUAL:   cfg_reg.max_visual   <= cfg_wdata[4:0];
                default:
                begin
                end
            endcase
        end
    end

    sebu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .entry_index (entry_index),
        .entry_size  (entry_size),
        .now_tick    (now_tick),
        .take        (cq_take),
        .avail       (cq_avail),
        .item        (cq_item)
    );

    sebu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .avail   (cq_avail),
        .item    (cq_item),
        .take    (cq_take),
        .rq_wr   (rq_wr),
        .rq_din  (rq_din),
        .rq_full (rq_full)
    );

    sebu_rq u_rq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (rq_wr),
        .din     (rq_din),
        .rq_full (rq_full),
        .pop     (pop),
        .empty   (empty),
        .dout    (rq_dout)
    );

    assign kind = rq_dout.kind;
    assign slot = rq_dout.slot;
    assign last = rq_dout.last;

endmodule

/* design/sebu_front.sv */
module sebu_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [1:0]             cmd,
    input  logic [3:0]             entry_index,
    input  logic [15:0]            entry_size,
    input  logic [31:0]            now_tick,
    input  logic                   take,
    output logic                   avail,
    output sebu_pkg::item_t        item
);

    sebu_pkg::item_t                   slot_reg [sebu_pkg::CQ_DEPTH];
    logic [sebu_pkg::CQ_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [sebu_pkg::CQ_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [sebu_pkg::CQ_CNT_W-1:0]     cnt_reg, cnt_next;
    sebu_pkg::item_t                   in_item;
    logic                              do_push;
    logic                              do_pop;

    // classify the incoming request
    always_comb
    begin
        in_item.cmd         = sebu_pkg::cmd_t'(cmd);
        in_item.entry_index = entry_index;
        in_item.entry_size  = entry_size;
        in_item.now_tick    = now_tick;
    end

    assign full    = (cnt_reg == sebu_pkg::CQ_CNT_W'(sebu_pkg::CQ_DEPTH));
    assign avail   = (cnt_reg != '0);
    assign item    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = take && avail;

    // pointer and count update
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* design/sebu_rq.sv */
module sebu_rq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  sebu_pkg::res_t din,
    output logic           rq_full,
    input  logic           pop,
    output logic           empty,
    output sebu_pkg::res_t dout
);

    sebu_pkg::res_t                    slot_reg [sebu_pkg::RQ_DEPTH];
    logic [sebu_pkg::RQ_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [sebu_pkg::RQ_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [sebu_pkg::RQ_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                              do_wr;
    logic                              do_pop;

    assign rq_full = (cnt_reg == sebu_pkg::RQ_CNT_W'(sebu_pkg::RQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign dout    = slot_reg[rd_ptr_reg];
    assign do_wr   = wr && !rq_full;
    assign do_pop  = pop && !empty;

    // pointer and count update
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_wr && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

/* design/sebu_back.sv */
module sebu_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sebu_pkg::cfg_t   cfg,
    input  logic             avail,
    input  sebu_pkg::item_t  item,
    output logic             take,
    output logic             rq_wr,
    output sebu_pkg::res_t   rq_din,
    input  logic             rq_full
);

    localparam logic [sebu_pkg::SCAN_W-1:0] SCAN_END_PAD = sebu_pkg::SCAN_W'(2);

    sebu_pkg::state_t                  state_reg, state_next;
    sebu_pkg::item_t                   item_reg, item_next;
    logic [sebu_pkg::SCAN_W-1:0]       i_reg, i_next;
    logic [sebu_pkg::NRES_W-1:0]       nres_reg, nres_next;
    logic [sebu_pkg::FILL_W-1:0]       fill_reg, fill_next;
    logic [sebu_pkg::FILL_W-1:0]       live_reg, live_next;
    logic [sebu_pkg::FILL_W-1:0]       vis_reg, vis_next;
    sebu_pkg::res_t                    pend_reg, pend_next;
    logic                              pend_v_reg, pend_v_next;

    // score pipeline
    logic                              p1_v_reg, p1_v_next;
    logic [31:0]                       p1_age_reg, p1_age_next;
    logic [15:0]                       p1_size_reg, p1_size_next;
    logic [sebu_pkg::IDX_W-1:0]        p1_idx_reg, p1_idx_next;
    logic                              p2_v_reg, p2_v_next;
    logic [sebu_pkg::SCORE_W-1:0]      p2_prod_reg, p2_prod_next;
    logic [sebu_pkg::IDX_W-1:0]        p2_idx_reg, p2_idx_next;
    logic                              found_reg, found_next;
    logic [sebu_pkg::SCORE_W-1:0]      best_reg, best_next;
    logic [sebu_pkg::IDX_W-1:0]        best_idx_reg, best_idx_next;

    // roster storage
    sebu_pkg::phase_t                  phase_reg [sebu_pkg::ROSTER_DEPTH];
    logic [31:0]                       settle_reg [sebu_pkg::ROSTER_DEPTH];
    logic [15:0]                       size_reg [sebu_pkg::ROSTER_DEPTH];

    logic                              ph_we;
    logic [sebu_pkg::IDX_W-1:0]        ph_addr;
    sebu_pkg::phase_t                  ph_val;
    logic                              st_we;
    logic [31:0]                       st_val;
    logic                              sz_we;
    logic [sebu_pkg::IDX_W-1:0]        data_addr;

    logic                              emit_en;
    sebu_pkg::res_t                    emit_res;
    logic                              emit_ok;
    logic [sebu_pkg::IDX_W-1:0]        cur;
    logic                              in_range;
    logic                              room;
    logic [31:0]                       cur_age;
    logic [sebu_pkg::SCAN_W-1:0]       fill_ext;

    assign cur      = i_reg[sebu_pkg::IDX_W-1:0];
    assign fill_ext = sebu_pkg::SCAN_W'(fill_reg);
    assign in_range = (i_reg < fill_ext);
    assign room     = (nres_reg < sebu_pkg::NRES_W'(sebu_pkg::MAX_RESULTS));
    assign cur_age  = item_reg.now_tick - settle_reg[cur];
    assign emit_ok  = !pend_v_reg || !rq_full;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        i_next        = i_reg;
        nres_next     = nres_reg;
        fill_next     = fill_reg;
        live_next     = live_reg;
        vis_next      = vis_reg;
        pend_next     = pend_reg;
        pend_v_next   = pend_v_reg;
        p1_v_next     = 1'b0;
        p1_age_next   = p1_age_reg;
        p1_size_next  = p1_size_reg;
        p1_idx_next   = p1_idx_reg;
        p2_v_next     = p1_v_reg;
        p2_prod_next  = sebu_pkg::SCORE_W'(p1_size_reg) * sebu_pkg::SCORE_W'(p1_age_reg);
        p2_idx_next   = p1_idx_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        take          = 1'b0;
        rq_wr         = 1'b0;
        rq_din        = pend_reg;
        emit_en       = 1'b0;
        emit_res      = pend_reg;
        ph_we         = 1'b0;
        ph_addr       = cur;
        ph_val        = sebu_pkg::PH_FROZEN;
        st_we         = 1'b0;
        st_val        = item_reg.now_tick;
        sz_we         = 1'b0;
        data_addr     = cur;

        unique case (state_reg)
            sebu_pkg::ST_IDLE:
            begin
                if (avail)
                begin
                    take       = 1'b1;
                    item_next  = item;
                    state_next = sebu_pkg::ST_DECODE;
                end
            end
            sebu_pkg::ST_DECODE:
            begin
                unique case (item_reg.cmd)
                    sebu_pkg::CMD_SPAWN:
                    begin
                        if (fill_reg < sebu_pkg::FILL_W'(sebu_pkg::ROSTER_DEPTH))
                        begin
                            data_addr  = fill_reg[sebu_pkg::IDX_W-1:0];
                            ph_addr    = fill_reg[sebu_pkg::IDX_W-1:0];
                            ph_we      = 1'b1;
                            ph_val     = sebu_pkg::PH_FALLING;
                            st_we      = 1'b1;
                            st_val     = '0;
                            sz_we      = 1'b1;
                            fill_next  = fill_reg + 1'b1;
                            live_next  = live_reg + 1'b1;
                            vis_next   = vis_reg + 1'b1;
                            pend_next  = '{kind: sebu_pkg::K_SPAWNED,
                                           slot: 4'(fill_reg), last: 1'b0};
                        end
                        else
                        begin
                            pend_next  = '{kind: sebu_pkg::K_REJECTED,
                                           slot: '0, last: 1'b0};
                        end
                        pend_v_next = 1'b1;
                        state_next  = sebu_pkg::ST_FINISH;
                    end
                    sebu_pkg::CMD_SETTLE:
                    begin
                        i_next     = sebu_pkg::SCAN_W'(item_reg.entry_index);
                        state_next = sebu_pkg::ST_SETTLE;
                    end
                    sebu_pkg::CMD_ENFORCE:
                    begin
                        i_next     = '0;
                        nres_next  = '0;
                        state_next = sebu_pkg::ST_FREEZE;
                    end
                    default:
                    begin
                        state_next = sebu_pkg::ST_FINISH;
                    end
                endcase
            end
            sebu_pkg::ST_SETTLE:
            begin
                if (in_range && phase_reg[cur] == sebu_pkg::PH_FALLING)
                begin
                    ph_we  = 1'b1;
                    ph_val = sebu_pkg::PH_SETTLED;
                    st_we  = 1'b1;
                end
                state_next = sebu_pkg::ST_FINISH;
            end
            // freeze entries that have lingered long enough
            sebu_pkg::ST_FREEZE:
            begin
                if (!in_range || !room)
                begin
                    state_next = sebu_pkg::ST_LIVE;
                end
                else if (phase_reg[cur] == sebu_pkg::PH_SETTLED
                         && cur_age >= cfg.freeze_delay)
                begin
                    if (emit_ok)
                    begin
                        emit_en   = 1'b1;
                        emit_res  = '{kind: sebu_pkg::K_FROZEN, slot: 4'(cur), last: 1'b0};
                        ph_we     = 1'b1;
                        live_next = live_reg - 1'b1;
                        i_next    = i_reg + 1'b1;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            sebu_pkg::ST_LIVE:
            begin
                i_next     = '0;
                found_next = 1'b0;
                p2_v_next  = 1'b0;
                if (room && 32'(live_reg) > 32'(cfg.max_live))
                begin
                    state_next = sebu_pkg::ST_SCORE;
                end
                else
                begin
                    state_next = sebu_pkg::ST_RETIRE_SETUP;
                end
            end
            // one scan for the highest size times age
            sebu_pkg::ST_SCORE:
            begin
                if (in_range)
                begin
                    p1_v_next    = (phase_reg[cur] == sebu_pkg::PH_SETTLED);
                    p1_age_next  = cur_age;
                    p1_size_next = size_reg[cur];
                    p1_idx_next  = cur;
                end
                if (i_reg != fill_ext + SCAN_END_PAD)
                begin
                    i_next = i_reg + 1'b1;
                end
                if (p2_v_reg && (!found_reg || p2_prod_reg > best_reg))
                begin
                    found_next    = 1'b1;
                    best_next     = p2_prod_reg;
                    best_idx_next = p2_idx_reg;
                end
                if (i_reg == fill_ext + SCAN_END_PAD)
                begin
                    if (!found_reg)
                    begin
                        state_next = sebu_pkg::ST_RETIRE_SETUP;
                    end
                    else if (emit_ok)
                    begin
                        emit_en    = 1'b1;
                        emit_res   = '{kind: sebu_pkg::K_FROZEN,
                                       slot: 4'(best_idx_reg), last: 1'b0};
                        ph_we      = 1'b1;
                        ph_addr    = best_idx_reg;
                        live_next  = live_reg - 1'b1;
                        state_next = sebu_pkg::ST_LIVE;
                    end
                end
            end
            sebu_pkg::ST_RETIRE_SETUP:
            begin
                i_next = '0;
                if (cfg.max_visual == '0)
                begin
                    state_next = sebu_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = sebu_pkg::ST_RETIRE;
                end
            end
            // retire lowest-index frozen entries in one pass
            sebu_pkg::ST_RETIRE:
            begin
                if (!in_range || !room || !(32'(vis_reg) > 32'(cfg.max_visual)))
                begin
                    state_next = sebu_pkg::ST_FINISH;
                end
                else if (phase_reg[cur] == sebu_pkg::PH_FROZEN)
                begin
                    if (emit_ok)
                    begin
                        emit_en  = 1'b1;
                        emit_res = '{kind: sebu_pkg::K_RETIRED, slot: 4'(cur), last: 1'b0};
                        ph_we    = 1'b1;
                        ph_val   = sebu_pkg::PH_RETIRED;
                        vis_next = vis_reg - 1'b1;
                        i_next   = i_reg + 1'b1;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            // final result carries the last flag
            sebu_pkg::ST_FINISH:
            begin
                if (!rq_full)
                begin
                    rq_wr = 1'b1;
                    if (pend_v_reg)
                    begin
                        rq_din = '{kind: pend_reg.kind, slot: pend_reg.slot, last: 1'b1};
                    end
                    else
                    begin
                        rq_din = '{kind: sebu_pkg::K_DONE, slot: '0, last: 1'b1};
                    end
                    pend_v_next = 1'b0;
                    state_next  = sebu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sebu_pkg::ST_IDLE;
            end
        endcase

        // a new result pushes the held one out
        if (emit_en)
        begin
            if (pend_v_reg)
            begin
                rq_wr  = 1'b1;
                rq_din = pend_reg;
            end
            pend_next   = emit_res;
            pend_v_next = 1'b1;
            nres_next   = nres_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sebu_pkg::ST_IDLE;
            fill_reg   <= '0;
            live_reg   <= '0;
            vis_reg    <= '0;
            pend_v_reg <= 1'b0;
            p1_v_reg   <= 1'b0;
            p2_v_reg   <= 1'b0;
            found_reg  <= 1'b0;
            i_reg      <= '0;
            nres_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            live_reg   <= live_next;
            vis_reg    <= vis_next;
            pend_v_reg <= pend_v_next;
            p1_v_reg   <= p1_v_next;
            p2_v_reg   <= p2_v_next;
            found_reg  <= found_next;
            i_reg      <= i_next;
            nres_reg   <= nres_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        pend_reg     <= pend_next;
        p1_age_reg   <= p1_age_next;
        p1_size_reg  <= p1_size_next;
        p1_idx_reg   <= p1_idx_next;
        p2_prod_reg  <= p2_prod_next;
        p2_idx_reg   <= p2_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
    end

    // roster writes
    always_ff @(posedge clk)
    begin
        if (ph_we)
        begin
            phase_reg[ph_addr] <= ph_val;
        end
        if (st_we)
        begin
            settle_reg[data_addr] <= st_val;
        end
        if (sz_we)
        begin
            size_reg[data_addr] <= item_reg.entry_size;
        end
    end

endmodule

/* design/sebu_checker.sv */
module sebu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [2:0] kind,
    input logic [3:0] slot,
    input logic       last
);

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(kind) && $stable(slot) && $stable(last))
        else $error("result changed while waiting");

    // spawn outcomes are single results
    a_spawn_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (kind == sebu_pkg::K_SPAWNED || kind == sebu_pkg::K_REJECTED) |-> last)
        else $error("spawn result without last");

    // done closes its request
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && kind == sebu_pkg::K_DONE |-> last)
        else $error("done without last");

    // slotless kinds carry slot zero
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (kind == sebu_pkg::K_DONE || kind == sebu_pkg::K_REJECTED) |-> slot == 4'd0)
        else $error("nonzero slot on slotless result");

endmodule

bind settled_entry_eviction_budget_unit sebu_checker u_sebu_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .empty (empty),
    .pop   (pop),
    .kind  (kind),
    .slot  (slot),
    .last  (last)
);
